@@ hdl/lssc_pkg.sv @@
// ----------------------------------------------------------------------------
// lssc_pkg
// shared types, widths, register codes and reset values for the line scan
// steering classifier
// ----------------------------------------------------------------------------
`default_nettype none

package lssc_pkg;

  localparam int unsigned PIX_W     = 12;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned TOT_W     = 6;
  localparam int unsigned SUB_W     = 5;
  localparam int unsigned POS_W     = 8;

  localparam int unsigned LINE_LENGTH_DEF = 128;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [TOT_W-1:0] tot_t;
  typedef logic [SUB_W-1:0] sub_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DARK_THR       = 3'd0,
    REG_INNER_THR      = 3'd1,
    REG_ANG_STRAIGHT   = 3'd2,
    REG_ANG_HALF_RIGHT = 3'd3,
    REG_ANG_FULL_RIGHT = 3'd4,
    REG_ANG_HALF_LEFT  = 3'd5,
    REG_ANG_FULL_LEFT  = 3'd6
  } cfg_idx_t;

  localparam pix_t RST_DARK_THR       = 12'd4000;
  localparam pix_t RST_INNER_THR      = 12'd3900;
  localparam pix_t RST_ANG_STRAIGHT   = 12'd1966;
  localparam pix_t RST_ANG_HALF_RIGHT = 12'd2158;
  localparam pix_t RST_ANG_FULL_RIGHT = 12'd2350;
  localparam pix_t RST_ANG_HALF_LEFT  = 12'd1774;
  localparam pix_t RST_ANG_FULL_LEFT  = 12'd1582;

  localparam pos_t POS_MAX = 8'd255;

  // window bounds, inclusive
  localparam pos_t LEFT_LO        = 8'd16;
  localparam pos_t LEFT_HI        = 8'd63;
  localparam pos_t RIGHT_LO       = 8'd64;
  localparam pos_t RIGHT_HI       = 8'd112;
  localparam pos_t FAR_LEFT_LO    = 8'd16;
  localparam pos_t FAR_LEFT_HI    = 8'd31;
  localparam pos_t MID_LEFT_LO    = 8'd34;
  localparam pos_t MID_LEFT_HI    = 8'd48;
  localparam pos_t INNER_LEFT_LO  = 8'd50;
  localparam pos_t INNER_LEFT_HI  = 8'd63;
  localparam pos_t INNER_RIGHT_LO = 8'd65;
  localparam pos_t INNER_RIGHT_HI = 8'd77;
  localparam pos_t MID_RIGHT_LO   = 8'd79;
  localparam pos_t MID_RIGHT_HI   = 8'd94;
  localparam pos_t FAR_RIGHT_LO   = 8'd96;
  localparam pos_t FAR_RIGHT_HI   = 8'd111;

  typedef struct packed {
    pix_t dark_thr;
    pix_t inner_thr;
    pix_t ang_straight;
    pix_t ang_half_right;
    pix_t ang_full_right;
    pix_t ang_half_left;
    pix_t ang_full_left;
  } cfg_t;

  typedef struct packed {
    tot_t left_total;
    tot_t right_total;
    sub_t far_left;
    sub_t mid_left;
    sub_t inner_left;
    sub_t inner_right;
    sub_t mid_right;
    sub_t far_right;
  } counts_t;

  typedef struct packed {
    logic update;
    pix_t angle;
  } steer_t;

  function automatic logic in_win(pos_t p, pos_t lo, pos_t hi);
    return (p >= lo) && (p <= hi);
  endfunction

endpackage

`default_nettype wire

@@ hdl/lssc_if.sv @@
// ----------------------------------------------------------------------------
// lssc_if
// pixel, result and register write channels, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface lssc_in_if import lssc_pkg::*; ();
  logic valid;
  logic ready;
  pix_t pixel;
  logic last_pixel;

  modport source (output valid, output pixel, output last_pixel, input ready);
  modport sink   (input valid, input pixel, input last_pixel, output ready);
endinterface

interface lssc_out_if import lssc_pkg::*; ();
  logic valid;
  logic ready;
  logic steer_update;
  pix_t steer_angle;
  tot_t left_dark;
  tot_t right_dark;

  modport source (output valid, output steer_update, output steer_angle,
                  output left_dark, output right_dark, input ready);
  modport sink   (input valid, input steer_update, input steer_angle,
                  input left_dark, input right_dark, output ready);
endinterface

interface lssc_cfg_if import lssc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  pix_t                 data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/line_scan_steering_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// line_scan_steering_classifier_unit
// line scan steering classifier: dark pixel counts per line, servo angle pick
// ----------------------------------------------------------------------------
// Takes one pixel per clock with no gaps needed between pixels or lines. Each
// pixel passes an input register, then updates the window counters; on the
// last pixel of a line (marked, or at position LINE_LENGTH-1) the decision is
// made in the same cycle and loaded into the result register, so a line's
// result reaches the output through the input and result registers. The input stalls
// only while a line's last pixel waits in the input register because an
// earlier result still sits unread in the result register. Register writes
// are taken at any time, one per cycle, and belong to the idle periods
// between lines.
// ----------------------------------------------------------------------------
`default_nettype none

module line_scan_steering_classifier_unit import lssc_pkg::*; #(
  parameter int unsigned LINE_LENGTH = LINE_LENGTH_DEF
) (
  input wire logic      clk,
  input wire logic      rst_n,
  lssc_in_if.sink       in_ch,
  lssc_out_if.source    out_ch,
  lssc_cfg_if.sink      cfg_ch
);

  cfg_t    cfg;
  counts_t cnt;
  steer_t  steer;
  logic    line_end;

  logic    s1_valid_r;
  pix_t    s1_pixel_r;
  logic    s1_last_r;
  logic    s1_adv;
  logic    in_acc;
  logic    out_load;

  logic    out_valid_r;
  steer_t  out_steer_r;
  tot_t    out_left_r;
  tot_t    out_right_r;

  assign cfg_ch.ready = 1'b1;

  lssc_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_ch.valid),
    .wr_idx  (cfg_ch.index),
    .wr_data (cfg_ch.data),
    .cfg_o   (cfg)
  );

  assign s1_adv       = s1_valid_r && (!line_end || !out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_load     = s1_adv && line_end;

  lssc_accum #(
    .LINE_LENGTH (LINE_LENGTH)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_adv),
    .pixel      (s1_pixel_r),
    .last_pixel (s1_last_r),
    .dark_thr   (cfg.dark_thr),
    .inner_thr  (cfg.inner_thr),
    .cnt_o      (cnt),
    .line_end_o (line_end)
  );

  lssc_decide u_decide (
    .cnt     (cnt),
    .cfg     (cfg),
    .steer_o (steer)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc || (s1_valid_r && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pixel_r <= in_ch.pixel;
      s1_last_r  <= in_ch.last_pixel;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_steer_r <= steer;
      out_left_r  <= cnt.left_total;
      out_right_r <= cnt.right_total;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.steer_update = out_steer_r.update;
  assign out_ch.steer_angle  = out_steer_r.angle;
  assign out_ch.left_dark    = out_left_r;
  assign out_ch.right_dark   = out_right_r;

endmodule

`default_nettype wire

@@ hdl/lssc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// lssc_cfg_regs
// thresholds and servo angle registers, written through the config channel
// ----------------------------------------------------------------------------
`default_nettype none

module lssc_cfg_regs import lssc_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_en,
  input  wire [CFG_IDX_W-1:0] wr_idx,
  input  wire pix_t           wr_data,
  output cfg_t                cfg_o
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dark_thr       <= RST_DARK_THR;
      cfg_r.inner_thr      <= RST_INNER_THR;
      cfg_r.ang_straight   <= RST_ANG_STRAIGHT;
      cfg_r.ang_half_right <= RST_ANG_HALF_RIGHT;
      cfg_r.ang_full_right <= RST_ANG_FULL_RIGHT;
      cfg_r.ang_half_left  <= RST_ANG_HALF_LEFT;
      cfg_r.ang_full_left  <= RST_ANG_FULL_LEFT;
    end else if (wr_en) begin
      unique case (cfg_idx_t'(wr_idx))
        REG_DARK_THR:       cfg_r.dark_thr       <= wr_data;
        REG_INNER_THR:      cfg_r.inner_thr      <= wr_data;
        REG_ANG_STRAIGHT:   cfg_r.ang_straight   <= wr_data;
        REG_ANG_HALF_RIGHT: cfg_r.ang_half_right <= wr_data;
        REG_ANG_FULL_RIGHT: cfg_r.ang_full_right <= wr_data;
        REG_ANG_HALF_LEFT:  cfg_r.ang_half_left  <= wr_data;
        REG_ANG_FULL_LEFT:  cfg_r.ang_full_left  <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

`default_nettype wire

@@ hdl/lssc_accum.sv @@
// ----------------------------------------------------------------------------
// lssc_accum
// line position and dark pixel counters over the halves and sub-windows
// ----------------------------------------------------------------------------
`default_nettype none

module lssc_accum import lssc_pkg::*; #(
  parameter int unsigned LINE_LENGTH = LINE_LENGTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic step,
  input  wire pix_t pixel,
  input  wire logic last_pixel,
  input  wire pix_t dark_thr,
  input  wire pix_t inner_thr,
  output counts_t   cnt_o,
  output logic      line_end_o
);

  localparam pos_t LAST_POS = POS_W'(LINE_LENGTH - 1);

  pos_t    pos_r;
  pos_t    pos_nxt;
  counts_t cnt_r;
  counts_t cnt_nxt;
  logic    dark;
  logic    dark_inner;

  always_comb begin
    dark       = pixel < dark_thr;
    dark_inner = pixel < inner_thr;

    cnt_nxt.left_total  = cnt_r.left_total
                        + TOT_W'(dark && in_win(pos_r, LEFT_LO, LEFT_HI));
    cnt_nxt.right_total = cnt_r.right_total
                        + TOT_W'(dark && in_win(pos_r, RIGHT_LO, RIGHT_HI));
    cnt_nxt.far_left    = cnt_r.far_left
                        + SUB_W'(dark && in_win(pos_r, FAR_LEFT_LO, FAR_LEFT_HI));
    cnt_nxt.mid_left    = cnt_r.mid_left
                        + SUB_W'(dark && in_win(pos_r, MID_LEFT_LO, MID_LEFT_HI));
    cnt_nxt.inner_left  = cnt_r.inner_left
                        + SUB_W'(dark_inner && in_win(pos_r, INNER_LEFT_LO, INNER_LEFT_HI));
    cnt_nxt.inner_right = cnt_r.inner_right
                        + SUB_W'(dark && in_win(pos_r, INNER_RIGHT_LO, INNER_RIGHT_HI));
    cnt_nxt.mid_right   = cnt_r.mid_right
                        + SUB_W'(dark && in_win(pos_r, MID_RIGHT_LO, MID_RIGHT_HI));
    cnt_nxt.far_right   = cnt_r.far_right
                        + SUB_W'(dark && in_win(pos_r, FAR_RIGHT_LO, FAR_RIGHT_HI));

    pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + POS_W'(1);

    line_end_o = last_pixel || (pos_r == LAST_POS);
    cnt_o      = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      cnt_r <= '0;
    end else if (step) begin
      if (line_end_o) begin
        pos_r <= '0;
        cnt_r <= '0;
      end else begin
        pos_r <= pos_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/lssc_decide.sv @@
// ----------------------------------------------------------------------------
// lssc_decide
// picks the heavier half and its strictly largest sub-window, maps it to a
// servo angle
// ----------------------------------------------------------------------------
`default_nettype none

module lssc_decide import lssc_pkg::*; (
  input  wire counts_t cnt,
  input  wire cfg_t    cfg,
  output steer_t       steer_o
);

  function automatic logic strict_max(sub_t a, sub_t b, sub_t c);
    return (a > b) && (a > c);
  endfunction

  always_comb begin
    steer_o = '0;
    if (cnt.left_total > cnt.right_total) begin
      if (strict_max(cnt.far_left, cnt.mid_left, cnt.inner_left)) begin
        steer_o = '{update: 1'b1, angle: cfg.ang_straight};
      end else if (strict_max(cnt.mid_left, cnt.far_left, cnt.inner_left)) begin
        steer_o = '{update: 1'b1, angle: cfg.ang_half_right};
      end else if (strict_max(cnt.inner_left, cnt.far_left, cnt.mid_left)) begin
        steer_o = '{update: 1'b1, angle: cfg.ang_full_right};
      end
    end else if (cnt.right_total > cnt.left_total) begin
      if (strict_max(cnt.far_right, cnt.mid_right, cnt.inner_right)) begin
        steer_o = '{update: 1'b1, angle: cfg.ang_straight};
      end else if (strict_max(cnt.mid_right, cnt.far_right, cnt.inner_right)) begin
        steer_o = '{update: 1'b1, angle: cfg.ang_half_left};
      end else if (strict_max(cnt.inner_right, cnt.far_right, cnt.mid_right)) begin
        steer_o = '{update: 1'b1, angle: cfg.ang_full_left};
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/lssc_checker.sv @@
// ----------------------------------------------------------------------------
// lssc_checker
// port level checks on the result channel of the steering classifier
// ----------------------------------------------------------------------------
`default_nettype none

module lssc_checker import lssc_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic steer_update,
  input wire pix_t steer_angle,
  input wire tot_t left_dark,
  input wire tot_t right_dark
);

  localparam tot_t LEFT_MAX  = 6'd48;
  localparam tot_t RIGHT_MAX = 6'd49;

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(steer_update) && $stable(steer_angle)
                                && $stable(left_dark) && $stable(right_dark))
    else $error("result changed while stalled");

  a_equal_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (left_dark == right_dark) |-> !steer_update)
    else $error("update on equal halves");

  a_no_update_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !steer_update |-> steer_angle == '0)
    else $error("angle not zero without update");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (left_dark <= LEFT_MAX) && (right_dark <= RIGHT_MAX))
    else $error("dark count beyond window size");

endmodule

bind line_scan_steering_classifier_unit lssc_checker u_lssc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .steer_update (out_ch.steer_update),
  .steer_angle  (out_ch.steer_angle),
  .left_dark    (out_ch.left_dark),
  .right_dark   (out_ch.right_dark)
);

`default_nettype wire

@@ test/line_scan_steering_classifier_unit_tb.sv @@
// ----------------------------------------------------------------------------
// line_scan_steering_classifier_unit_tb
// self-checking bench for the line scan steering classifier
// ----------------------------------------------------------------------------
// Pixels are streamed in as whole lines, some marked at their last pixel and
// some left to end by length. A scoreboard keeps its own copy of the window
// counters and registers, predicts the result of every line and checks each
// result transaction in order. A set of hand-built lines hits every window,
// every angle, the threshold edges and the cases that give no update. Random
// lines follow under several register settings, including the extremes. Both
// sides idle at random, the result side holds off for long stretches, and
// the pixel side drains the block now and then.
// ----------------------------------------------------------------------------

module line_scan_steering_classifier_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lssc_pkg::*;

  localparam int unsigned LINE_LEN      = LINE_LENGTH_DEF;
  localparam int          CYCLE_LIMIT   = 600000;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          SETTLE_CYCLES = 6;

  typedef struct packed {
    logic update;
    pix_t angle;
    tot_t left_dark;
    tot_t right_dark;
  } steer_res_t;

  typedef enum int {
    RG_FAR_L, RG_MID_L, RG_INNER_L, RG_INNER_R, RG_MID_R, RG_FAR_R, RG_OTHER
  } region_t;

  class line_steer_scoreboard;
    cfg_t       cfg;
    counts_t    cnt;
    pos_t       pos;
    steer_res_t steer_q[$];
    int         mismatches;

    function new();
      cfg.dark_thr       = RST_DARK_THR;
      cfg.inner_thr      = RST_INNER_THR;
      cfg.ang_straight   = RST_ANG_STRAIGHT;
      cfg.ang_half_right = RST_ANG_HALF_RIGHT;
      cfg.ang_full_right = RST_ANG_FULL_RIGHT;
      cfg.ang_half_left  = RST_ANG_HALF_LEFT;
      cfg.ang_full_left  = RST_ANG_FULL_LEFT;
      cnt        = '0;
      pos        = '0;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, pix_t v);
      case (idx)
        REG_DARK_THR:       cfg.dark_thr       = v;
        REG_INNER_THR:      cfg.inner_thr      = v;
        REG_ANG_STRAIGHT:   cfg.ang_straight   = v;
        REG_ANG_HALF_RIGHT: cfg.ang_half_right = v;
        REG_ANG_FULL_RIGHT: cfg.ang_full_right = v;
        REG_ANG_HALF_LEFT:  cfg.ang_half_left  = v;
        REG_ANG_FULL_LEFT:  cfg.ang_full_left  = v;
        default: ;
      endcase
    endfunction

    function bit in_span(pos_t p, pos_t lo, pos_t hi);
      return (p >= lo) && (p <= hi);
    endfunction

    function void take_pixel(pix_t px, logic last_pix);
      steer_res_t res;
      if (px < cfg.dark_thr) begin
        if (in_span(pos, LEFT_LO, LEFT_HI))
          cnt.left_total  = cnt.left_total + 1'b1;
        if (in_span(pos, RIGHT_LO, RIGHT_HI))
          cnt.right_total = cnt.right_total + 1'b1;
        if (in_span(pos, FAR_LEFT_LO, FAR_LEFT_HI))
          cnt.far_left    = cnt.far_left + 1'b1;
        if (in_span(pos, MID_LEFT_LO, MID_LEFT_HI))
          cnt.mid_left    = cnt.mid_left + 1'b1;
        if (in_span(pos, INNER_RIGHT_LO, INNER_RIGHT_HI))
          cnt.inner_right = cnt.inner_right + 1'b1;
        if (in_span(pos, MID_RIGHT_LO, MID_RIGHT_HI))
          cnt.mid_right   = cnt.mid_right + 1'b1;
        if (in_span(pos, FAR_RIGHT_LO, FAR_RIGHT_HI))
          cnt.far_right   = cnt.far_right + 1'b1;
      end
      if (px < cfg.inner_thr && in_span(pos, INNER_LEFT_LO, INNER_LEFT_HI))
        cnt.inner_left = cnt.inner_left + 1'b1;

      if (!last_pix && pos != LINE_LEN - 1) begin
        if (pos != POS_MAX) pos++;
        return;
      end

      res            = '0;
      res.left_dark  = cnt.left_total;
      res.right_dark = cnt.right_total;
      if (cnt.left_total > cnt.right_total) begin
        if (cnt.far_left > cnt.mid_left && cnt.far_left > cnt.inner_left)
          {res.update, res.angle} = {1'b1, cfg.ang_straight};
        else if (cnt.mid_left > cnt.far_left && cnt.mid_left > cnt.inner_left)
          {res.update, res.angle} = {1'b1, cfg.ang_half_right};
        else if (cnt.inner_left > cnt.far_left && cnt.inner_left > cnt.mid_left)
          {res.update, res.angle} = {1'b1, cfg.ang_full_right};
      end else if (cnt.right_total > cnt.left_total) begin
        if (cnt.far_right > cnt.mid_right && cnt.far_right > cnt.inner_right)
          {res.update, res.angle} = {1'b1, cfg.ang_straight};
        else if (cnt.mid_right > cnt.far_right && cnt.mid_right > cnt.inner_right)
          {res.update, res.angle} = {1'b1, cfg.ang_half_left};
        else if (cnt.inner_right > cnt.far_right && cnt.inner_right > cnt.mid_right)
          {res.update, res.angle} = {1'b1, cfg.ang_full_left};
      end
      steer_q.push_back(res);
      cnt = '0;
      pos = '0;
    endfunction

    function void check_steer(logic upd, pix_t ang, tot_t ldark, tot_t rdark);
      steer_res_t exp_res;
      if (steer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with none pending: update=%0d angle=%0d left=%0d right=%0d",
                   $realtime, upd, ang, ldark, rdark);
        return;
      end
      exp_res = steer_q.pop_front();
      if (exp_res.update !== upd || exp_res.angle !== ang ||
          exp_res.left_dark !== ldark || exp_res.right_dark !== rdark) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: steer mismatch: expected update=%0d angle=%0d left=%0d right=%0d",
                   $realtime, exp_res.update, exp_res.angle, exp_res.left_dark,
                   exp_res.right_dark);
          $display("%0t: steer mismatch: got update=%0d angle=%0d left=%0d right=%0d",
                   $realtime, upd, ang, ldark, rdark);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  lssc_in_if  in_ch ();
  lssc_out_if out_ch ();
  lssc_cfg_if cfg_ch ();

  line_scan_steering_classifier_unit #(
    .LINE_LENGTH (LINE_LEN)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  line_steer_scoreboard sb = new();

  int   tx_gap_max   = 7;
  int   rx_wait_max  = 7;
  bit   hold_request = 1'b0;
  int   cycle_count  = 0;
  pix_t line_buf [LINE_LEN];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("line_scan_steering_classifier_unit_tb: FAIL");
    $finish;
  end

  // result side: random waits per transaction, long hold on request
  initial begin : result_sink
    int wait_left;
    int hold_left;
    wait_left = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        sb.check_steer(out_ch.steer_update, out_ch.steer_angle,
                       out_ch.left_dark, out_ch.right_dark);
        wait_left = $urandom_range(0, rx_wait_max);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (wait_left > 0) begin
        wait_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_pixel(pix_t px, logic last_pix);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.pixel      <= px;
    in_ch.last_pixel <= last_pix;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.take_pixel(px, last_pix);
  endtask

  task automatic write_cfg(cfg_idx_t idx, pix_t v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.set_reg(idx, v);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.steer_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void paint(int lo, int hi, pix_t v);
    for (int p = lo; p <= hi; p++) line_buf[p] = v;
  endfunction

  task automatic send_line(int len, bit marked);
    for (int p = 0; p < len; p++) send_pixel(line_buf[p], marked && p == len - 1);
  endtask

  function automatic region_t region_of(int p);
    if (p >= FAR_LEFT_LO && p <= FAR_LEFT_HI)       return RG_FAR_L;
    if (p >= MID_LEFT_LO && p <= MID_LEFT_HI)       return RG_MID_L;
    if (p >= INNER_LEFT_LO && p <= INNER_LEFT_HI)   return RG_INNER_L;
    if (p >= INNER_RIGHT_LO && p <= INNER_RIGHT_HI) return RG_INNER_R;
    if (p >= MID_RIGHT_LO && p <= MID_RIGHT_HI)     return RG_MID_R;
    if (p >= FAR_RIGHT_LO && p <= FAR_RIGHT_HI)     return RG_FAR_R;
    return RG_OTHER;
  endfunction

  // dark below both thresholds, light at or above both, some noise and edges
  function automatic pix_t gen_pixel(int pct);
    int lo;
    int hi;
    int r;
    lo = (sb.cfg.dark_thr < sb.cfg.inner_thr) ? sb.cfg.dark_thr : sb.cfg.inner_thr;
    hi = (sb.cfg.dark_thr < sb.cfg.inner_thr) ? sb.cfg.inner_thr : sb.cfg.dark_thr;
    r  = $urandom_range(0, 99);
    if (r < 8) return pix_t'($urandom_range(0, 4095));
    if (r < 12) begin
      case ($urandom_range(0, 3))
        0:       return sb.cfg.dark_thr - 1'b1;
        1:       return sb.cfg.dark_thr;
        2:       return sb.cfg.inner_thr - 1'b1;
        default: return sb.cfg.inner_thr;
      endcase
    end
    if ($urandom_range(0, 99) < pct)
      return (lo == 0) ? pix_t'(0) : pix_t'($urandom_range(0, lo - 1));
    return pix_t'($urandom_range(hi, 4095));
  endfunction

  task automatic send_random_line(output int sent);
    int len;
    int r;
    bit marked;
    int dark_pct [0:RG_OTHER];
    r      = $urandom_range(0, 99);
    marked = 1'b1;
    if (r < 4) begin
      len    = LINE_LEN;
      marked = 1'b0;
    end else if (r < 6) begin
      len = LINE_LEN;
    end else if (r < 10) begin
      len = $urandom_range(65, LINE_LEN - 1);
    end else if (r < 45) begin
      len = $urandom_range(17, 64);
    end else begin
      len = $urandom_range(1, 16);
    end
    foreach (dark_pct[k]) dark_pct[k] = 25 * $urandom_range(0, 4);
    for (int p = 0; p < len; p++)
      send_pixel(gen_pixel(dark_pct[region_of(p)]), marked && p == len - 1);
    sent = len;
  endtask

  task automatic run_directed();
    pos_t win_lo [6];
    pos_t win_hi [6];
    win_lo = '{FAR_LEFT_LO, MID_LEFT_LO, INNER_LEFT_LO,
               FAR_RIGHT_LO, MID_RIGHT_LO, INNER_RIGHT_LO};
    win_hi = '{FAR_LEFT_HI, MID_LEFT_HI, INNER_LEFT_HI,
               FAR_RIGHT_HI, MID_RIGHT_HI, INNER_RIGHT_HI};

    // one-pixel lines at both pixel extremes
    line_buf[0] = '0;
    send_line(1, 1'b1);
    line_buf[0] = '1;
    send_line(1, 1'b1);

    // each window dark on its own, every angle once
    for (int k = 0; k < 6; k++) begin
      paint(0, LINE_LEN - 1, '1);
      paint(win_lo[k], win_hi[k], '0);
      send_line(win_hi[k] + 1, 1'b1);
    end

    // equal halves
    paint(0, LINE_LEN - 1, '1);
    paint(LEFT_HI - 3, RIGHT_LO + 3, '0);
    send_line(RIGHT_LO + 4, 1'b1);

    // tie between far and inner left
    paint(0, LINE_LEN - 1, '1);
    paint(FAR_LEFT_LO, FAR_LEFT_LO + 13, '0);
    paint(INNER_LEFT_LO, INNER_LEFT_HI, '0);
    send_line(INNER_LEFT_HI + 1, 1'b1);

    // dark for the halves but not for the inner left threshold
    paint(0, LINE_LEN - 1, '1);
    paint(INNER_LEFT_LO, INNER_LEFT_HI, RST_INNER_THR + 12'd50);
    send_line(INNER_LEFT_HI + 1, 1'b1);

    // threshold edges
    paint(0, LINE_LEN - 1, '1);
    paint(FAR_LEFT_LO, FAR_LEFT_HI, RST_DARK_THR - 12'd1);
    paint(MID_LEFT_LO, MID_LEFT_HI, RST_DARK_THR);
    send_line(MID_LEFT_HI + 1, 1'b1);

    // short line marked mid window
    paint(0, LINE_LEN - 1, '1);
    paint(FAR_LEFT_LO, FAR_LEFT_HI, '0);
    paint(MID_LEFT_LO, 40, '0);
    send_line(41, 1'b1);

    // dark only outside the sub-windows, partly past the right half, ends by length
    paint(0, LINE_LEN - 1, '1);
    paint(0, FAR_LEFT_LO - 1, '0);
    paint(RIGHT_LO, RIGHT_LO, '0);
    paint(RIGHT_HI, LINE_LEN - 1, '0);
    send_line(LINE_LEN, 1'b0);
  endtask

  task automatic load_phase_cfg(int ph);
    case (ph)
      1: begin
        write_cfg(REG_DARK_THR,       pix_t'($urandom_range(1000, 4095)));
        write_cfg(REG_INNER_THR,      pix_t'($urandom_range(0, 4095)));
        write_cfg(REG_ANG_STRAIGHT,   pix_t'($urandom_range(0, 4095)));
        write_cfg(REG_ANG_HALF_RIGHT, pix_t'($urandom_range(0, 4095)));
        write_cfg(REG_ANG_FULL_RIGHT, pix_t'($urandom_range(0, 4095)));
        write_cfg(REG_ANG_HALF_LEFT,  pix_t'($urandom_range(0, 4095)));
        write_cfg(REG_ANG_FULL_LEFT,  pix_t'($urandom_range(0, 4095)));
      end
      2: begin
        write_cfg(REG_DARK_THR,       '1);
        write_cfg(REG_INNER_THR,      '0);
        write_cfg(REG_ANG_STRAIGHT,   '0);
        write_cfg(REG_ANG_HALF_RIGHT, '1);
        write_cfg(REG_ANG_FULL_RIGHT, '0);
        write_cfg(REG_ANG_HALF_LEFT,  '1);
        write_cfg(REG_ANG_FULL_LEFT,  '0);
      end
      3: begin
        write_cfg(REG_DARK_THR,       '0);
        write_cfg(REG_INNER_THR,      '1);
        write_cfg(REG_ANG_STRAIGHT,   '1);
        write_cfg(REG_ANG_HALF_RIGHT, '0);
        write_cfg(REG_ANG_FULL_RIGHT, '1);
        write_cfg(REG_ANG_HALF_LEFT,  '0);
        write_cfg(REG_ANG_FULL_LEFT,  '1);
      end
      4: begin
        write_cfg(REG_DARK_THR,       12'd1);
        write_cfg(REG_INNER_THR,      12'd1);
        write_cfg(REG_ANG_STRAIGHT,   pix_t'($urandom_range(0, 4095)));
        write_cfg(REG_ANG_HALF_RIGHT, pix_t'($urandom_range(0, 4095)));
        write_cfg(REG_ANG_FULL_RIGHT, pix_t'($urandom_range(0, 4095)));
        write_cfg(REG_ANG_HALF_LEFT,  pix_t'($urandom_range(0, 4095)));
        write_cfg(REG_ANG_FULL_LEFT,  pix_t'($urandom_range(0, 4095)));
      end
      default: begin
        write_cfg(REG_DARK_THR,       pix_t'($urandom_range(2000, 4095)));
        write_cfg(REG_INNER_THR,      pix_t'($urandom_range(1, 4095)));
        write_cfg(REG_ANG_STRAIGHT,   RST_ANG_STRAIGHT);
        write_cfg(REG_ANG_HALF_RIGHT, RST_ANG_HALF_RIGHT);
        write_cfg(REG_ANG_FULL_RIGHT, RST_ANG_FULL_RIGHT);
        write_cfg(REG_ANG_HALF_LEFT,  RST_ANG_HALF_LEFT);
        write_cfg(REG_ANG_FULL_LEFT,  RST_ANG_FULL_LEFT);
      end
    endcase
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_random(int ph);
    int items;
    int lines;
    int sent;
    int min_lines;
    items     = 0;
    lines     = 0;
    min_lines = (ph == 2) ? 3 : 2;
    while (items < 30 || lines < min_lines) begin
      if (lines == 0 && (ph == 2 || ph == 4)) hold_request = 1'b1;
      if (lines == 1 && ph == 4) settle();
      send_random_line(sent);
      items += sent;
      lines++;
    end
  endtask

  initial begin : stimulus
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.pixel      <= '0;
    in_ch.last_pixel <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= REG_DARK_THR;
    cfg_ch.data      <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      tx_gap_max  = (ph == 0 || ph == 2) ? 0 : 7;
      rx_wait_max = (ph == 0 || ph == 3) ? 0 : 7;
      if (ph > 0) load_phase_cfg(ph);
      run_random(ph);
    end
    settle();

    if (sb.mismatches == 0 && sb.steer_q.size() == 0)
      $display("line_scan_steering_classifier_unit_tb: PASS");
    else
      $display("line_scan_steering_classifier_unit_tb: FAIL");
    $finish;
  end

endmodule
